FILE: rtl/edf_task_scheduler_macros.svh
// Assertion macros for the scheduler
`ifndef EDF_TASK_SCHEDULER_MACROS_SVH
`define EDF_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define EDF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edf: label failed");
`define EDF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edf: label failed");
`else
`define EDF_ASSERT_IMP(label, clk, rst, ante, cons)
`define EDF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/edf_pkg.sv
`default_nettype none
package edf_pkg;
  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_SEMS_DEF = 4;
  localparam logic [31:0] NO_WAKEUP = 32'h7FFF_FFFF;
  localparam logic [31:0] CLOCK_TOP = 32'hFFFF_FFFF;
  localparam logic [7:0] SEM_MAX = 8'd255;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_CREATE = 3'd1;
  localparam logic [2:0] MODE_SLEEP = 3'd2;
  localparam logic [2:0] MODE_WAIT = 3'd3;
  localparam logic [2:0] MODE_SIGNAL = 3'd4;
  localparam logic [2:0] MODE_TERM = 3'd5;
  localparam logic [2:0] MODE_SEM = 3'd6;

  localparam logic [4:0] ST_TERMINATED = 5'd0;
  localparam logic [4:0] ST_READY = 5'd1;
  localparam logic [4:0] ST_SLEEP = 5'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_ACTION, S_SIGSCAN, S_SIGAPPLY, S_SCAN, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic action;
    logic sig_clear;
    logic sig_step;
    logic sig_apply;
    logic scan_clear;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sig_event;
    logic sig_last;
    logic scan_last;
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/edf_ctrl.sv
`default_nettype none
`include "edf_task_scheduler_macros.svh"
module edf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire edf_pkg::status_t  status,
  output edf_pkg::cmd_t          cmd
);
  edf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      edf_pkg::S_IDLE: if (in_valid) state_next = edf_pkg::S_ACTION;
      edf_pkg::S_ACTION: state_next = status.sig_event ?
                                      edf_pkg::S_SIGSCAN : edf_pkg::S_SCAN;
      edf_pkg::S_SIGSCAN: if (status.sig_last) state_next = edf_pkg::S_SIGAPPLY;
      edf_pkg::S_SIGAPPLY: state_next = edf_pkg::S_SCAN;
      edf_pkg::S_SCAN: if (status.scan_last) state_next = edf_pkg::S_DONE;
      edf_pkg::S_DONE: if (!out_stall) state_next = edf_pkg::S_IDLE;
      default: state_next = edf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      edf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.start = in_valid;
      end
      edf_pkg::S_ACTION: begin
        cmd.action = 1'b1;
        cmd.sig_clear = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      edf_pkg::S_SIGSCAN: cmd.sig_step = 1'b1;
      edf_pkg::S_SIGAPPLY: cmd.sig_apply = 1'b1;
      edf_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.finish = status.scan_last;
      end
      edf_pkg::S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  `EDF_ASSERT_IMP(a_stall_busy, clk, rst, state != edf_pkg::S_IDLE, in_stall)
  `EDF_ASSERT_NXT(a_start_act, clk, rst, cmd.start, state == edf_pkg::S_ACTION)
  `EDF_ASSERT_NXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

FILE: rtl/edf_datapath.sv
`default_nettype none
module edf_datapath #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  parameter int MAX_SEMAPHORES = edf_pkg::MAX_SEMS_DEF,
  localparam int TW = $clog2(MAX_TASKS + 1),
  localparam int SW = (MAX_SEMAPHORES > 1) ? $clog2(MAX_SEMAPHORES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire edf_pkg::cmd_t     cmd,
  output edf_pkg::status_t       status,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        mode,
  input  wire logic [31:0]       release_time,
  input  wire logic [31:0]       deadline_time,
  input  wire logic [2:0]        sem_index,
  input  wire logic [7:0]        sem_init,
  output logic [3:0]             running_task,
  output logic                   switched,
  output logic [31:0]            next_wakeup,
  output logic [31:0]            current_time,
  output logic                   table_full
);
  logic [31:0] idle_deadline;
  logic [31:0] tick_clock;
  logic [TW-1:0] task_count;
  logic [TW-1:0] current_task;
  logic [31:0] rel_q [1:MAX_TASKS];
  logic [31:0] dl_q [1:MAX_TASKS];
  logic [4:0] st_q [1:MAX_TASKS];
  logic [7:0] sem_q [MAX_SEMAPHORES];

  // latched event
  logic [2:0] ev_mode;
  logic [31:0] ev_rel, ev_dl;
  logic [2:0] ev_sem;
  logic [7:0] ev_init;

  logic [TW-1:0] idx;
  logic [TW-1:0] pick;
  logic [31:0] min_dl;
  logic [TW-1:0] best;
  logic [31:0] best_dl;
  logic [31:0] wake;

  logic sem_ok, cur_ok, idx_live;
  logic [SW-1:0] sidx;
  logic [4:0] wait_code;
  logic [TW:0] idx_inc;

  logic [TW-1:0] final_best;
  logic [31:0] final_wake;

  assign sem_ok = (ev_sem >= 3'd1) && ({29'd0, ev_sem} <= 32'(MAX_SEMAPHORES));
  assign sidx = SW'(ev_sem - 3'd1);
  assign wait_code = 5'd2 + {2'd0, ev_sem};
  assign cur_ok = current_task != '0;
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign idx_live = idx <= task_count;
  assign status.sig_event = (ev_mode == edf_pkg::MODE_SIGNAL);
  assign status.sig_last = (idx >= task_count);
  assign status.scan_last = (idx >= task_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_deadline <= edf_pkg::NO_WAKEUP;
      tick_clock <= '0;
      task_count <= '0;
      current_task <= '0;
      for (int i = 1; i <= MAX_TASKS; i++) st_q[i] <= edf_pkg::ST_TERMINATED;
      for (int s = 0; s < MAX_SEMAPHORES; s++) sem_q[s] <= '0;
    end else begin
      if (cfg_we) idle_deadline <= cfg_data;
      if (cmd.start) begin
        ev_mode <= mode;
        ev_rel <= release_time;
        ev_dl <= deadline_time;
        ev_sem <= sem_index;
        ev_init <= sem_init;
        table_full <= 1'b0;
      end
      if (cmd.action) begin
        case (ev_mode)
          edf_pkg::MODE_TICK: begin
            // restart clock before wrap: rebase live tasks
            if (tick_clock == edf_pkg::CLOCK_TOP) begin
              for (int i = 1; i <= MAX_TASKS; i++) begin
                if (TW'(i) <= task_count && st_q[i] != edf_pkg::ST_TERMINATED) begin
                  rel_q[i] <= rel_q[i] - tick_clock;
                  dl_q[i] <= dl_q[i] - tick_clock;
                end
              end
              tick_clock <= 32'd1;
            end else begin
              tick_clock <= tick_clock + 32'd1;
            end
          end
          edf_pkg::MODE_CREATE: begin
            if (32'(task_count) >= 32'(MAX_TASKS)) begin
              table_full <= 1'b1;
            end else begin
              task_count <= task_count + 1'b1;
              rel_q[task_count + 1'b1] <= ev_rel;
              dl_q[task_count + 1'b1] <= ev_dl;
              st_q[task_count + 1'b1] <= edf_pkg::ST_SLEEP;
            end
          end
          edf_pkg::MODE_SLEEP: if (cur_ok) begin
            st_q[current_task] <= edf_pkg::ST_SLEEP;
            dl_q[current_task] <= dl_q[current_task] + ev_dl;
            rel_q[current_task] <= rel_q[current_task] + ev_rel;
          end
          edf_pkg::MODE_WAIT: if (cur_ok && sem_ok) begin
            if (sem_q[sidx] != 8'd0) sem_q[sidx] <= sem_q[sidx] - 8'd1;
            else st_q[current_task] <= wait_code;
          end
          edf_pkg::MODE_TERM: if (cur_ok) st_q[current_task] <= edf_pkg::ST_TERMINATED;
          edf_pkg::MODE_SEM: if (sem_ok) sem_q[sidx] <= ev_init;
          default: ;
        endcase
      end
      if (cmd.sig_clear || cmd.scan_clear) begin
        idx <= TW'(1);
        pick <= '0;
        min_dl <= edf_pkg::CLOCK_TOP;
        best <= '0;
        best_dl <= idle_deadline;
        wake <= edf_pkg::NO_WAKEUP;
      end
      // one waiter entry per cycle, later index wins ties
      if (cmd.sig_step) begin
        if (idx_live && sem_ok && st_q[idx] == wait_code && dl_q[idx] <= min_dl) begin
          pick <= idx;
          min_dl <= dl_q[idx];
        end
        idx <= status.sig_last ? TW'(1) : idx_inc[TW-1:0];
      end
      if (cmd.sig_apply && sem_ok) begin
        if (pick == '0) begin
          if (sem_q[sidx] < edf_pkg::SEM_MAX) sem_q[sidx] <= sem_q[sidx] + 8'd1;
        end else begin
          st_q[pick] <= edf_pkg::ST_READY;
        end
      end
      // one task per cycle: wake, then select
      if (cmd.scan_step && idx_live) begin
        if (st_q[idx] == edf_pkg::ST_SLEEP && rel_q[idx] <= tick_clock) begin
          st_q[idx] <= edf_pkg::ST_READY;
          if (dl_q[idx] < best_dl) begin
            best <= idx;
            best_dl <= dl_q[idx];
          end
        end else begin
          if (st_q[idx] == edf_pkg::ST_SLEEP && rel_q[idx] < wake) wake <= rel_q[idx];
          if (st_q[idx] == edf_pkg::ST_READY && dl_q[idx] < best_dl) begin
            best <= idx;
            best_dl <= dl_q[idx];
          end
        end
      end
      if (cmd.scan_step && !status.scan_last) idx <= idx_inc[TW-1:0];
      if (cmd.finish) begin
        // final candidate is folded here
        running_task <= 4'(final_best);
        switched <= final_best != current_task;
        current_task <= final_best;
        next_wakeup <= final_wake;
        current_time <= tick_clock;
      end
    end
  end

  always_comb begin
    final_best = best;
    final_wake = wake;
    if (idx_live) begin
      if (st_q[idx] == edf_pkg::ST_SLEEP && rel_q[idx] <= tick_clock) begin
        if (dl_q[idx] < best_dl) final_best = idx;
      end else begin
        if (st_q[idx] == edf_pkg::ST_SLEEP && rel_q[idx] < wake) final_wake = rel_q[idx];
        if (st_q[idx] == edf_pkg::ST_READY && dl_q[idx] < best_dl) final_best = idx;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/edf_task_scheduler.sv
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (idle_deadline)
// in      | in        | in_valid/in_stall   | mode, release_time, deadline_time, sem_index, sem_init
// out     | out       | out_valid/out_stall | running_task, switched, next_wakeup, current_time,
//         |           |                     | table_full
// An event runs the action step, for a signal a scan of the waiters and an apply step, then
// a one-entry-per-cycle scan of the task table; the result then waits until taken.
// rst is synchronous: clock, table, semaphores cleared, idle_deadline set to 0x7FFFFFFF.
// in_stall stays high from accept until the result beat leaves.
`default_nettype none
module edf_task_scheduler #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  parameter int MAX_SEMAPHORES = edf_pkg::MAX_SEMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] release_time,
  input  wire logic [31:0] deadline_time,
  input  wire logic [2:0]  sem_index,
  input  wire logic [7:0]  sem_init,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       running_task,
  output logic             switched,
  output logic [31:0]      next_wakeup,
  output logic [31:0]      current_time,
  output logic             table_full
);
  edf_pkg::cmd_t cmd;
  edf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  edf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  edf_datapath #(.MAX_TASKS(MAX_TASKS), .MAX_SEMAPHORES(MAX_SEMAPHORES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_data(cfg_data), .cfg_we(cfg_valid),
    .mode(mode), .release_time(release_time), .deadline_time(deadline_time),
    .sem_index(sem_index), .sem_init(sem_init),
    .running_task(running_task), .switched(switched), .next_wakeup(next_wakeup),
    .current_time(current_time), .table_full(table_full)
  );
endmodule
`default_nettype wire

FILE: dv/edf_task_checker.sv
`timescale 1ns / 100ps
module edf_task_checker
  import edf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [31:0] release_time,
  input  logic [31:0] deadline_time,
  input  logic [2:0]  sem_index,
  input  logic [7:0]  sem_init,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  running_task,
  input  logic        switched,
  input  logic [31:0] next_wakeup,
  input  logic [31:0] current_time,
  input  logic        table_full,
  output int          fails,
  output int          pending
);
  localparam int NTASK = MAX_TASKS_DEF;
  localparam int NSEM = MAX_SEMS_DEF;

  typedef struct packed {
    logic [3:0]  task_id;
    logic        switched;
    logic [31:0] wakeup;
    logic [31:0] now;
    logic        full;
  } decision_t;

  decision_t   decisions_due[$];
  logic [31:0] idle_dl;
  logic [31:0] clock_now;
  int          n_tasks;
  int          running;
  logic [31:0] rel_tab [0:NTASK];
  logic [31:0] dl_tab [0:NTASK];
  logic [4:0]  st_tab [0:NTASK];
  logic [7:0]  sem_cnt [0:NSEM-1];

  initial fails = 0;
  assign pending = decisions_due.size();

  task automatic clear_scheduler();
    idle_dl = NO_WAKEUP;
    clock_now = '0;
    n_tasks = 0;
    running = 0;
    for (int i = 0; i <= NTASK; i++) begin
      rel_tab[i] = '0;
      dl_tab[i] = '0;
      st_tab[i] = ST_TERMINATED;
    end
    for (int i = 0; i < NSEM; i++) sem_cnt[i] = '0;
  endtask

  task automatic schedule_event(input logic [2:0] m, input logic [31:0] rel,
                                input logic [31:0] dl, input logic [2:0] si,
                                input logic [7:0] init);
    logic [31:0] wake;
    logic [31:0] best_dl;
    logic [31:0] min_dl;
    logic [4:0]  wait_code;
    int          best;
    int          pick;
    logic        full;
    bit          sem_valid;
    decision_t   d;
    full = 1'b0;
    sem_valid = (si >= 1) && (si <= NSEM);
    wait_code = ST_SLEEP + 5'(si);
    case (m)
      MODE_TICK: begin
        if (clock_now == CLOCK_TOP) begin
          // shift every live task down before the clock wraps
          for (int i = 1; i <= n_tasks; i++)
            if (st_tab[i] != ST_TERMINATED) begin
              rel_tab[i] -= clock_now;
              dl_tab[i] -= clock_now;
            end
          clock_now = '0;
        end
        clock_now++;
      end
      MODE_CREATE: begin
        if (n_tasks >= NTASK) full = 1'b1;
        else begin
          n_tasks++;
          rel_tab[n_tasks] = rel;
          dl_tab[n_tasks] = dl;
          st_tab[n_tasks] = ST_SLEEP;
        end
      end
      MODE_SLEEP: begin
        if (running != 0) begin
          st_tab[running] = ST_SLEEP;
          dl_tab[running] += dl;
          rel_tab[running] += rel;
        end
      end
      MODE_WAIT: begin
        if (running != 0 && sem_valid) begin
          if (sem_cnt[si-1] > 0) sem_cnt[si-1]--;
          else st_tab[running] = wait_code;
        end
      end
      MODE_SIGNAL: begin
        if (sem_valid) begin
          pick = 0;
          min_dl = CLOCK_TOP;
          // highest index wins a deadline tie among waiters
          for (int i = 1; i <= n_tasks; i++)
            if (st_tab[i] == wait_code && dl_tab[i] <= min_dl) begin
              pick = i;
              min_dl = dl_tab[i];
            end
          if (pick == 0) begin
            if (sem_cnt[si-1] < SEM_MAX) sem_cnt[si-1]++;
          end else st_tab[pick] = ST_READY;
        end
      end
      MODE_TERM: begin
        if (running != 0) st_tab[running] = ST_TERMINATED;
      end
      MODE_SEM: begin
        if (sem_valid) sem_cnt[si-1] = init;
      end
      default: ;
    endcase

    wake = NO_WAKEUP;
    best = 0;
    best_dl = idle_dl;
    for (int i = 1; i <= n_tasks; i++) begin
      if (st_tab[i] == ST_SLEEP) begin
        if (rel_tab[i] <= clock_now) st_tab[i] = ST_READY;
        else if (rel_tab[i] < wake) wake = rel_tab[i];
      end
      if (st_tab[i] == ST_READY && dl_tab[i] < best_dl) begin
        best = i;
        best_dl = dl_tab[i];
      end
    end
    d.task_id = 4'(best);
    d.switched = (best != running);
    d.wakeup = wake;
    d.now = clock_now;
    d.full = full;
    running = best;
    decisions_due.push_back(d);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scheduler();
      decisions_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) idle_dl = cfg_data;
      if (out_valid && !out_stall) begin
        if (decisions_due.size() == 0) begin
          $error("result beat with no pending event");
          fails++;
        end else begin
          decision_t d;
          d = decisions_due.pop_front();
          if (running_task !== d.task_id) begin
            $error("running_task: expected %0d, actual %0d", d.task_id, running_task);
            fails++;
          end
          if (switched !== d.switched) begin
            $error("switched: expected %0d, actual %0d", d.switched, switched);
            fails++;
          end
          if (next_wakeup !== d.wakeup) begin
            $error("next_wakeup: expected %h, actual %h", d.wakeup, next_wakeup);
            fails++;
          end
          if (current_time !== d.now) begin
            $error("current_time: expected %h, actual %h", d.now, current_time);
            fails++;
          end
          if (table_full !== d.full) begin
            $error("table_full: expected %0d, actual %0d", d.full, table_full);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        schedule_event(mode, release_time, deadline_time, sem_index, sem_init);
    end
  end
endmodule

FILE: dv/edf_task_scheduler_test.sv
`timescale 1ns / 100ps
module edf_task_scheduler_test;
  import edf_pkg::*;

  localparam logic [2:0] MODE_NOP = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = '0;
  logic [31:0] release_time = '0;
  logic [31:0] deadline_time = '0;
  logic [2:0]  sem_index = '0;
  logic [7:0]  sem_init = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  running_task;
  logic        switched;
  logic [31:0] next_wakeup;
  logic [31:0] current_time;
  logic        table_full;
  int          fails;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [31:0] ticks_sent = '0;

  always #2 clk = ~clk;

  edf_task_scheduler uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_stall, .mode,
    .release_time, .deadline_time, .sem_index, .sem_init, .out_valid, .out_stall,
    .running_task, .switched, .next_wakeup, .current_time, .table_full
  );

  edf_task_checker chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_stall, .mode,
    .release_time, .deadline_time, .sem_index, .sem_init, .out_valid, .out_stall,
    .running_task, .switched, .next_wakeup, .current_time, .table_full,
    .fails, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: one long hold to fill the block, then random bursts
  initial begin
    @(negedge rst);
    repeat (400) @(posedge clk);
    out_stall <= 1'b1;
    repeat (300) @(posedge clk);
    out_stall <= 1'b0;
    while (!calm) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_event(input logic [2:0] m, input logic [31:0] rel,
                            input logic [31:0] dl, input logic [2:0] si,
                            input logic [7:0] init);
    in_valid <= 1'b1;
    mode <= m;
    release_time <= rel;
    deadline_time <= dl;
    sem_index <= si;
    sem_init <= init;
    // stall is sampled at the edge itself, before the block updates
    @(posedge clk iff !in_stall);
    if (m == MODE_TICK) ticks_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_idle_deadline(input logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_event();
    logic [2:0]  m;
    logic [31:0] rel;
    logic [31:0] dl;
    logic [2:0]  si;
    int          pick;
    pick = $urandom_range(0, 199);
    if (pick < 60) m = MODE_TICK;
    else if (pick < 76) m = MODE_CREATE;
    else if (pick < 106) m = MODE_SLEEP;
    else if (pick < 136) m = MODE_WAIT;
    else if (pick < 170) m = MODE_SIGNAL;
    else if (pick < 172) m = MODE_TERM;
    else if (pick < 194) m = MODE_SEM;
    else m = MODE_NOP;
    // mostly near-term releases so sleepers do wake up
    if ($urandom_range(0, 9) == 0) rel = $urandom;
    else if (m == MODE_CREATE) rel = ticks_sent + $urandom_range(0, 20);
    else rel = $urandom_range(0, 20);
    if ($urandom_range(0, 1) == 0) dl = $urandom;
    else dl = $urandom_range(0, 1000);
    si = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    send_event(m, rel, dl, si, 8'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // idle task running: apart from the tick, these only reschedule
    send_event(MODE_TICK, 0, 0, 1, 0);
    send_event(MODE_SLEEP, 5, 5, 1, 0);
    send_event(MODE_WAIT, 0, 0, 1, 0);
    send_event(MODE_TERM, 0, 0, 1, 0);
    send_event(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 8'hFF);
    send_event(MODE_CREATE, 0, 100, 0, 0);
    send_event(MODE_CREATE, 3, 50, 0, 0);
    send_event(MODE_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_event(MODE_SEM, 0, 0, 1, 0);
    send_event(MODE_WAIT, 0, 0, 1, 0);
    send_event(MODE_SIGNAL, 0, 0, 1, 0);
    send_event(MODE_SIGNAL, 0, 0, 2, 0);
    send_event(MODE_SEM, 0, 0, 4, 8'hFF);
    send_event(MODE_SIGNAL, 0, 0, 4, 0);
    send_event(MODE_WAIT, 0, 0, 4, 0);
    send_event(MODE_WAIT, 0, 0, 0, 0);
    send_event(MODE_SIGNAL, 0, 0, 5, 0);
    send_event(MODE_SEM, 0, 0, 7, 8'h55);
    repeat (4) send_event(MODE_TICK, 0, 0, 1, 0);
    send_event(MODE_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    send_event(MODE_TERM, 0, 0, 1, 0);

    write_idle_deadline(32'hFFFF_FFFF);
    repeat (PHASE_ITEMS) random_event();
    write_idle_deadline(32'h0000_0000);
    repeat (PHASE_ITEMS / 5) random_event();
    write_idle_deadline($urandom);
    repeat (PHASE_ITEMS) random_event();
    write_idle_deadline(32'hFFFF_FFFF);
    repeat (PHASE_ITEMS / 2) random_event();
    write_idle_deadline(NO_WAKEUP);
    calm = 1'b1;
    repeat (PHASE_ITEMS) random_event();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
